// File: rtl/tcp_pkg.sv
// Shared types, codes and helper functions of the tuple command parser.
// Used by tcp_parser, tcp_result_fifo, tuple_command_parser_unit and tcp_checker.
`timescale 1ns / 1ps

package tcp_pkg;

   localparam int TCP_MAX_FIELDS = 5;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [30:0] INT_SAT = 31'h7FFF_FFFF;
   localparam logic [15:0] POS_SAT = 16'hFFFF;

   // record kinds
   localparam logic [1:0] REC_FIELD  = 2'd0;
   localparam logic [1:0] REC_SBYTE  = 2'd1;
   localparam logic [1:0] REC_ACCEPT = 2'd2;
   localparam logic [1:0] REC_ERROR  = 2'd3;

   // matchers
   localparam logic [2:0] MATCH_EQ  = 3'd0;
   localparam logic [2:0] MATCH_LT  = 3'd1;
   localparam logic [2:0] MATCH_LE  = 3'd2;
   localparam logic [2:0] MATCH_GT  = 3'd3;
   localparam logic [2:0] MATCH_GE  = 3'd4;
   localparam logic [2:0] MATCH_ANY = 3'd5;

   // operations
   localparam logic [2:0] OP_INPUT   = 3'd0;
   localparam logic [2:0] OP_OUTPUT  = 3'd1;
   localparam logic [2:0] OP_READ    = 3'd2;
   localparam logic [2:0] OP_EXIT    = 3'd3;
   localparam logic [2:0] OP_CLEANUP = 3'd4;
   localparam logic [2:0] OP_NONE    = 3'd7;

   // characters
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;

   localparam logic [0:0] CSR_MODE = 1'b0;

   typedef struct packed {
      logic [1:0]  record_kind;
      logic [2:0]  field_index;
      logic [2:0]  matcher;
      logic        value_type;
      logic [30:0] number_value;
      logic [7:0]  string_byte;
      logic [15:0] string_length;
      logic [2:0]  operation;
      logic [30:0] timeout_value;
      logic [15:0] error_position;
      logic        last;
   } rec_type;

   typedef struct packed {
      logic [1:0] count;
      rec_type    rec0;
      rec_type    rec1;
   } push_type;

   function automatic logic [2:0] kw_first_op(input logic [7:0] c);
      case (c)
         "i":     kw_first_op = OP_INPUT;
         "o":     kw_first_op = OP_OUTPUT;
         "r":     kw_first_op = OP_READ;
         "e":     kw_first_op = OP_EXIT;
         "c":     kw_first_op = OP_CLEANUP;
         default: kw_first_op = OP_NONE;
      endcase
   endfunction

   function automatic logic [2:0] kw_len(input logic [2:0] op);
      case (op)
         OP_OUTPUT:  kw_len = 3'd6;
         OP_READ:    kw_len = 3'd4;
         OP_EXIT:    kw_len = 3'd4;
         OP_CLEANUP: kw_len = 3'd7;
         default:    kw_len = 3'd5;
      endcase
   endfunction

   function automatic logic [7:0] kw_char(input logic [2:0] op, input logic [2:0] off);
      logic [63:0] txt;
      logic [2:0]  slot;
      case (op)
         OP_OUTPUT:  txt = {"output", 16'h0};
         OP_READ:    txt = {"read", 32'h0};
         OP_EXIT:    txt = {"exit", 32'h0};
         OP_CLEANUP: txt = {"cleanup", 8'h0};
         default:    txt = {"input", 24'h0};
      endcase
      slot = 3'd7 - off;
      kw_char = txt[{slot, 3'b000} +: 8];
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic [30:0] acc_digit(input logic [30:0] a, input logic [7:0] c);
      logic [34:0] v;
      v = 35'({a, 3'b000}) + 35'({a, 1'b0}) + 35'(c[3:0]);
      acc_digit = (v > 35'(INT_SAT)) ? INT_SAT : v[30:0];
   endfunction

   function automatic logic [15:0] plus_one(input logic [15:0] p);
      plus_one = (p == POS_SAT) ? POS_SAT : p + 16'd1;
   endfunction

endpackage

// File: rtl/tcp_parser.sv
// Line parser state machine: consumes one character per item and produces
// up to two result records. Depends on tcp_pkg.
`timescale 1ns / 1ps

module tcp_parser import tcp_pkg::*; #(
   parameter int MAX_FIELDS = TCP_MAX_FIELDS
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step_en,
   input  logic [7:0] char_code,
   input  logic       tuple_only,
   output push_type   push
);

   localparam int FW = $clog2(MAX_FIELDS + 1);

   typedef enum logic [3:0] {
      PH_START, PH_KEYWORD, PH_PRE_TUPLE, PH_LOOP_TOP, PH_NODE_WS, PH_LT, PH_GT,
      PH_VALUE_WS, PH_INT, PH_STR, PH_AFTER_FIELD, PH_TIMEOUT_WS, PH_TIMEOUT,
      PH_TAIL_WS, PH_BARE_END, PH_SKIP
   } phase_type;

   phase_type       phase_ff, phase_in, close_phase;
   logic [2:0]      op_ff, op_in;
   logic [2:0]      kwoff_ff, kwoff_in, kwoff_inc;
   logic [15:0]     kwstart_ff, kwstart_in;
   logic [FW-1:0]   fields_ff, fields_in;
   logic [2:0]      pm_ff, pm_in;
   logic [30:0]     acc_ff, acc_in;
   logic [15:0]     scount_ff, scount_in;
   logic [15:0]     pos_ff, pos_in, pos1;
   logic [7:0]      c;
   logic            dig;
   logic            do_node, do_value, do_after, do_tail;
   logic            fld_emit, fld_vtype, sb_emit, vd_emit, vd_ok;
   logic [2:0]      fld_matcher;
   logic [30:0]     fld_ival;
   logic [15:0]     fld_slen, vd_pos;
   rec_type         rec_fld, rec_vd;
   logic [1:0]      nrec;

   assign c         = char_code;
   assign dig       = is_digit(char_code);
   assign pos1      = plus_one(pos_ff);
   assign kwoff_inc = kwoff_ff + 3'd1;

   always_comb begin
      if (tuple_only) begin
         close_phase = PH_BARE_END;
      end else if (op_ff == OP_OUTPUT) begin
         close_phase = PH_TAIL_WS;
      end else begin
         close_phase = PH_TIMEOUT_WS;
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      op_in       = op_ff;
      kwoff_in    = kwoff_ff;
      kwstart_in  = kwstart_ff;
      fields_in   = fields_ff;
      pm_in       = pm_ff;
      acc_in      = acc_ff;
      scount_in   = scount_ff;
      pos_in      = pos1;
      do_node     = 1'b0;
      do_value    = 1'b0;
      do_after    = 1'b0;
      do_tail     = 1'b0;
      fld_emit    = 1'b0;
      fld_vtype   = 1'b0;
      fld_matcher = MATCH_EQ;
      fld_ival    = '0;
      fld_slen    = '0;
      sb_emit     = 1'b0;
      vd_emit     = 1'b0;
      vd_ok       = 1'b0;
      vd_pos      = '0;

      unique case (phase_ff)
         PH_START: begin
            if (tuple_only) begin
               if (c == CH_SPACE) begin
                  phase_in = PH_PRE_TUPLE;
               end else if (c == CH_LPAREN) begin
                  phase_in = PH_LOOP_TOP;
               end else if (pos_ff == '0 && (c == CH_NL || c == CH_NUL)) begin
                  vd_emit = 1'b1;
                  vd_ok   = 1'b1;
               end else begin
                  vd_emit = 1'b1;
                  vd_pos  = pos1;
               end
            end else if (c != CH_SPACE) begin
               if (kw_first_op(c) != OP_NONE) begin
                  op_in      = kw_first_op(c);
                  kwstart_in = pos_ff;
                  kwoff_in   = 3'd1;
                  phase_in   = PH_KEYWORD;
               end else begin
                  vd_emit = 1'b1;
                  vd_pos  = pos1;
               end
            end
         end
         PH_KEYWORD: begin
            if (kwoff_ff < kw_len(op_ff) && c == kw_char(op_ff, kwoff_ff)) begin
               kwoff_in = kwoff_inc;
               if (kwoff_inc >= kw_len(op_ff)) begin
                  if (op_ff == OP_EXIT || op_ff == OP_CLEANUP) begin
                     vd_emit = 1'b1;
                     vd_ok   = 1'b1;
                  end else begin
                     phase_in = PH_PRE_TUPLE;
                  end
               end
            end else begin
               vd_emit = 1'b1;
               vd_pos  = plus_one(kwstart_ff);
            end
         end
         PH_PRE_TUPLE: begin
            if (c == CH_LPAREN) begin
               phase_in = PH_LOOP_TOP;
            end else if (c != CH_SPACE) begin
               vd_emit = 1'b1;
               vd_pos  = pos1;
            end
         end
         PH_LOOP_TOP: begin
            if (c == CH_RPAREN) begin
               phase_in = close_phase;
            end else begin
               do_node = 1'b1;
            end
         end
         PH_NODE_WS: begin
            do_node = 1'b1;
         end
         PH_LT: begin
            phase_in = PH_VALUE_WS;
            if (c == CH_EQ) begin
               pm_in = MATCH_LE;
            end else begin
               pm_in    = MATCH_LT;
               do_value = 1'b1;
            end
         end
         PH_GT: begin
            phase_in = PH_VALUE_WS;
            if (c == CH_EQ) begin
               pm_in = MATCH_GE;
            end else begin
               pm_in    = MATCH_GT;
               do_value = 1'b1;
            end
         end
         PH_VALUE_WS: begin
            do_value = 1'b1;
         end
         PH_INT: begin
            if (dig) begin
               acc_in = acc_digit(acc_ff, c);
            end else begin
               fld_emit    = 1'b1;
               fld_matcher = pm_ff;
               fld_ival    = acc_ff;
               fields_in   = fields_ff + FW'(1);
               phase_in    = PH_AFTER_FIELD;
               do_after    = 1'b1;
            end
         end
         PH_STR: begin
            if (c == CH_NUL) begin
               vd_emit = 1'b1;
               vd_pos  = pos1;
            end else if (c == CH_QUOTE) begin
               fld_emit    = 1'b1;
               fld_matcher = pm_ff;
               fld_vtype   = 1'b1;
               fld_slen    = scount_ff;
               fields_in   = fields_ff + FW'(1);
               phase_in    = PH_AFTER_FIELD;
            end else begin
               sb_emit   = 1'b1;
               scount_in = plus_one(scount_ff);
            end
         end
         PH_AFTER_FIELD: begin
            do_after = 1'b1;
         end
         PH_TIMEOUT_WS: begin
            if (dig) begin
               acc_in   = 31'(c[3:0]);
               phase_in = PH_TIMEOUT;
            end else if (c != CH_SPACE) begin
               vd_emit = 1'b1;
               vd_pos  = pos1;
            end
         end
         PH_TIMEOUT: begin
            if (dig) begin
               acc_in = acc_digit(acc_ff, c);
            end else begin
               do_tail = 1'b1;
            end
         end
         PH_TAIL_WS: begin
            do_tail = 1'b1;
         end
         PH_BARE_END: begin
            vd_emit = 1'b1;
            vd_ok   = (c == CH_NL || c == CH_NUL);
            vd_pos  = pos1;
         end
         PH_SKIP: begin
            phase_in = (c == CH_NUL) ? PH_START : PH_SKIP;
         end
      endcase

      if (do_node) begin
         pm_in    = MATCH_EQ;
         phase_in = PH_NODE_WS;
         if (c == CH_LT) begin
            phase_in = PH_LT;
         end else if (c == CH_GT) begin
            phase_in = PH_GT;
         end else if (c != CH_SPACE) begin
            phase_in = PH_VALUE_WS;
            do_value = 1'b1;
         end
      end

      if (do_value && c != CH_SPACE) begin
         if (dig) begin
            acc_in   = 31'(c[3:0]);
            phase_in = PH_INT;
         end else if (c == CH_QUOTE) begin
            scount_in = '0;
            phase_in  = PH_STR;
         end else if (c == CH_STAR) begin
            fld_emit    = 1'b1;
            fld_matcher = MATCH_ANY;
            fields_in   = fields_ff + FW'(1);
            phase_in    = PH_AFTER_FIELD;
         end else begin
            vd_emit = 1'b1;
            vd_pos  = pos1;
         end
      end

      if (do_after && c != CH_SPACE) begin
         if (fields_in < FW'(MAX_FIELDS) && c == CH_COMMA) begin
            phase_in = PH_LOOP_TOP;
         end else if (c == CH_RPAREN) begin
            phase_in = close_phase;
         end else begin
            vd_emit = 1'b1;
            vd_pos  = pos1;
         end
      end

      if (do_tail) begin
         phase_in = PH_TAIL_WS;
         if (c != CH_SPACE) begin
            vd_emit = 1'b1;
            vd_ok   = (c == CH_NUL);
            vd_pos  = pos1;
         end
      end

      if (vd_emit) begin
         phase_in = (c == CH_NUL) ? PH_START : PH_SKIP;
      end

      // a finished line, or a byte 0 that lands at line start, clears everything
      if (phase_in == PH_START && (c == CH_NUL || fld_emit || sb_emit || vd_emit)) begin
         op_in      = OP_INPUT;
         kwoff_in   = '0;
         kwstart_in = '0;
         fields_in  = '0;
         pm_in      = MATCH_EQ;
         acc_in     = '0;
         scount_in  = '0;
         pos_in     = '0;
      end
   end

   always_comb begin
      rec_fld = '0;
      if (sb_emit) begin
         rec_fld.record_kind = REC_SBYTE;
         rec_fld.field_index = 3'(fields_ff);
         rec_fld.matcher     = pm_ff;
         rec_fld.value_type  = 1'b1;
         rec_fld.string_byte = c;
      end else begin
         rec_fld.record_kind   = REC_FIELD;
         rec_fld.field_index   = 3'(fields_ff);
         rec_fld.matcher       = fld_matcher;
         rec_fld.value_type    = fld_vtype;
         rec_fld.number_value  = fld_ival;
         rec_fld.string_length = fld_slen;
      end

      rec_vd      = '0;
      rec_vd.last = 1'b1;
      if (vd_ok) begin
         rec_vd.record_kind = REC_ACCEPT;
         if (!tuple_only) begin
            rec_vd.operation = op_ff;
            if (op_ff == OP_INPUT || op_ff == OP_READ) begin
               rec_vd.timeout_value = acc_ff;
            end
         end
      end else begin
         rec_vd.record_kind    = REC_ERROR;
         rec_vd.error_position = vd_pos;
      end

      nrec = 2'({1'b0, fld_emit | sb_emit}) + 2'({1'b0, vd_emit});
      rec_fld.last = !vd_emit;

      push.count = step_en ? nrec : 2'd0;
      push.rec0  = (fld_emit || sb_emit) ? rec_fld : rec_vd;
      push.rec1  = rec_vd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_START;
         op_ff      <= OP_INPUT;
         kwoff_ff   <= '0;
         kwstart_ff <= '0;
         fields_ff  <= '0;
         pm_ff      <= MATCH_EQ;
         acc_ff     <= '0;
         scount_ff  <= '0;
         pos_ff     <= '0;
      end else if (step_en) begin
         phase_ff   <= phase_in;
         op_ff      <= op_in;
         kwoff_ff   <= kwoff_in;
         kwstart_ff <= kwstart_in;
         fields_ff  <= fields_in;
         pm_ff      <= pm_in;
         acc_ff     <= acc_in;
         scount_ff  <= scount_in;
         pos_ff     <= pos_in;
      end
   end

endmodule

// File: rtl/tcp_result_fifo.sv
// Small result queue: takes up to two records a cycle, hands out one.
// Depends on tcp_pkg.
`timescale 1ns / 1ps

module tcp_result_fifo import tcp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   output rec_type  head,
   output logic     head_valid,
   input  logic     head_stall,
   output logic     no_room
);

   rec_type               mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in, wr_next;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;
   logic                  pop;

   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];
   assign pop        = head_valid && !head_stall;
   assign no_room    = (count_ff > FIFO_CNT_W'(FIFO_DEPTH - 2));
   assign wr_next    = wr_ptr_ff + FIFO_PTR_W'(1);

   assign wr_ptr_in = wr_ptr_ff + FIFO_PTR_W'(push.count);
   assign rd_ptr_in = rd_ptr_ff + FIFO_PTR_W'(pop);
   assign count_in  = count_ff + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(pop);

   always_ff @(posedge clock) begin
      for (int i = 0; i < FIFO_DEPTH; i++) begin
         if (push.count != 2'd0 && wr_ptr_ff == FIFO_PTR_W'(i)) begin
            mem_ff[i] <= push.rec0;
         end else if (push.count == 2'd2 && wr_next == FIFO_PTR_W'(i)) begin
            mem_ff[i] <= push.rec1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: rtl/tuple_command_parser_unit.sv
// Top level of the tuple command parser: CSR port, line parser and result queue.
// Depends on tcp_pkg, tcp_parser and tcp_result_fifo.
`timescale 1ns / 1ps

// Usage:
//   req_ channel: one character per item (req_char_code); byte 0 ends a line.
//   rsp_ channel: result records (field done, string byte, accept, error);
//     rsp_last marks the final record caused by one character.
//   csr_ port: one register at byte addresses 0 to 3, bit 0 = tuple_only_mode
//     (bare tuple lines). Write it only while the block is idle.
// A record enters the result queue when its character is accepted and shows
//   on rsp_ once it reaches the queue head.
// Throughput: one character per cycle unless req_stall is high. A character
//   giving two records (a field closed by a bad character) sends them in turn;
//   the four-entry queue absorbs that; req_stall rises with fewer than two free.
// Receiver stall: rsp_ holds its record; the queue fills and then req_stall
//   holds the sender off. No record is dropped.
// Reset: synchronous; clears the parser to start of line, empties the
//   queue and sets full command line mode.

module tuple_command_parser_unit import tcp_pkg::*; #(
   parameter int MAX_FIELDS = TCP_MAX_FIELDS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_char_code,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_record_kind,
   output logic [2:0]            rsp_field_index,
   output logic [2:0]            rsp_matcher,
   output logic                  rsp_value_type,
   output logic [30:0]           rsp_number_value,
   output logic [7:0]            rsp_string_byte,
   output logic [15:0]           rsp_string_length,
   output logic [2:0]            rsp_operation,
   output logic [30:0]           rsp_timeout_value,
   output logic [15:0]           rsp_error_position,
   output logic                  rsp_last,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic     tuple_only_ff, tuple_only_in;
   logic     csr_write, req_accept, no_room;
   push_type push;
   rec_type  head;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign tuple_only_in = (csr_write && csr_paddr[CSR_ADDR_W-1] == CSR_MODE)
                          ? csr_pwdata[0] : tuple_only_ff;
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1] == CSR_MODE)
                       ? CSR_DATA_W'(tuple_only_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         tuple_only_ff <= 1'b0;
      end else begin
         tuple_only_ff <= tuple_only_in;
      end
   end

   assign req_stall  = no_room;
   assign req_accept = req_valid && !req_stall;

   tcp_parser #(
      .MAX_FIELDS (MAX_FIELDS)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .step_en    (req_accept),
      .char_code  (req_char_code),
      .tuple_only (tuple_only_ff),
      .push       (push)
   );

   tcp_result_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .head       (head),
      .head_valid (rsp_valid),
      .head_stall (rsp_stall),
      .no_room    (no_room)
   );

   assign rsp_record_kind    = head.record_kind;
   assign rsp_field_index    = head.field_index;
   assign rsp_matcher        = head.matcher;
   assign rsp_value_type     = head.value_type;
   assign rsp_number_value   = head.number_value;
   assign rsp_string_byte    = head.string_byte;
   assign rsp_string_length  = head.string_length;
   assign rsp_operation      = head.operation;
   assign rsp_timeout_value  = head.timeout_value;
   assign rsp_error_position = head.error_position;
   assign rsp_last           = head.last;

endmodule

// File: rtl/tcp_checker.sv
// Port-level checks of the tuple command parser, bound to the top level.
// Depends on tcp_pkg and tuple_command_parser_unit.
`timescale 1ns / 1ps

module tcp_checker import tcp_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_record_kind,
   input logic [30:0] rsp_number_value,
   input logic [15:0] rsp_error_position,
   input logic        rsp_last
);

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown right after reset");

   a_accept_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_record_kind == REC_ACCEPT |-> rsp_last)
      else $error("accept item not marked last");

   a_error_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_record_kind == REC_ERROR |-> rsp_last && rsp_error_position != 16'd0)
      else $error("error item without position or last mark");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_record_kind)
                                 && $stable(rsp_number_value) && $stable(rsp_error_position))
      else $error("stalled result item changed");

endmodule

bind tuple_command_parser_unit tcp_checker u_tcp_checker (.*);
